// File: rtl/core/kes_pkg.sv
// Shared types and constants for the keyed entry sorter.
`default_nettype none

package kes_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified request as it travels from front to back
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             store;   // 1: fits in the store, 0: dropped
  } kes_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/kes_ifs.sv
// Valid/ready channel interfaces for entry requests and sorted results.
`default_nettype none

interface kes_entry_if;
  import kes_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] entry_key;
  logic [TAG_W-1:0] entry_tag;
  logic             set_end;

  modport source (output valid, entry_key, entry_tag, set_end, input ready);
  modport sink   (input valid, entry_key, entry_tag, set_end, output ready);
endinterface

interface kes_result_if;
  import kes_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0] sorted_tag;
  logic             run_end;
  logic             entries_dropped;

  modport source (output valid, sorted_key, sorted_tag, run_end, entries_dropped,
                  input ready);
  modport sink   (input valid, sorted_key, sorted_tag, run_end, entries_dropped,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/kes_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kes_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kes_front.sv
// Front end: accepts entry requests, marks store/drop, queues them for the back end.
`default_nettype none

module kes_front #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  kes_entry_if.sink                entries,
  output kes_pkg::kes_entry_t      head,
  output logic                     head_valid,
  input  wire logic                pop
);
  import kes_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [QUEUE_AW:0] FULL_FILL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  logic [CW-1:0]       set_cnt;
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  kes_entry_t          queue [QUEUE_DEPTH];
  kes_entry_t          incoming;
  logic                push;
  logic                do_pop;

  assign entries.ready = (fill != FULL_FILL);
  assign push          = entries.valid && entries.ready;
  assign head_valid    = (fill != '0);
  assign do_pop        = pop && head_valid;
  assign head          = queue[rd_ptr];

  // Classify: entries past capacity are flagged for drop
  always_comb begin
    incoming.key   = entries.entry_key;
    incoming.tag   = entries.entry_tag;
    incoming.last  = entries.set_end;
    incoming.store = (set_cnt < MAX_CNT);
  end

  // Per-set fill count, mirrors the back end's store count
  always_ff @(posedge clk) begin
    if (rst) begin
      set_cnt <= '0;
    end else if (push) begin
      if (entries.set_end) begin
        set_cnt <= '0;
      end else if (incoming.store) begin
        set_cnt <= set_cnt + CW'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      priority if (push && !do_pop) begin
        fill <= fill + (QUEUE_AW + 1)'(1);
      end else if (!push && do_pop) begin
        fill <= fill - (QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kes_back.sv
// Back end: loads entries into the store, runs the exchange sort, emits results.
`default_nettype none

module kes_back #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kes_pkg::kes_entry_t head,
  input  wire logic                head_valid,
  output logic                     pop,
  kes_result_if.source             results
);
  import kes_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = KEY_W + TAG_W;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_IREAD = 3'd1;
  localparam logic [2:0] S_IWAIT = 3'd2;
  localparam logic [2:0] S_INNER = 3'd3;
  localparam logic [2:0] S_EREAD = 3'd4;
  localparam logic [2:0] S_EWAIT = 3'd5;

  logic [2:0]       state;
  logic [CW-1:0]    cnt;
  logic             ovf;
  logic [AW-1:0]    idx_i;
  logic [CW-1:0]    jr;
  logic [AW-1:0]    jp;
  logic             pend;
  logic [KEY_W-1:0] cur_key;
  logic [TAG_W-1:0] cur_tag;
  logic [AW-1:0]    eidx;

  logic             out_valid;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic             out_end;
  logic             out_drop;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [DW-1:0]    ram_rdata;

  logic [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0] rd_tag;
  logic             swap;
  logic             more_j;
  logic             last_i;
  logic             last_e;
  logic             out_free;

  assign rd_key   = ram_rdata[DW-1:TAG_W];
  assign rd_tag   = ram_rdata[TAG_W-1:0];
  // Pair (i,j) exchanges when a[i] < a[j]; a[i] lives in cur_key
  assign swap     = pend && (jp != idx_i) && (cur_key < rd_key);
  assign more_j   = (jr < cnt);
  assign last_i   = ((CW'(idx_i) + CW'(1)) == cnt);
  assign last_e   = ((CW'(eidx) + CW'(1)) == cnt);
  assign out_free = !out_valid || results.ready;
  assign pop      = (state == S_LOAD) && head_valid;

  assign results.valid           = out_valid;
  assign results.sorted_key      = out_key;
  assign results.sorted_tag      = out_tag;
  assign results.run_end         = out_end;
  assign results.entries_dropped = out_drop;

  kes_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = {head.key, head.tag};
    ram_re    = 1'b0;
    ram_raddr = idx_i;
    unique case (state)
      S_LOAD: begin
        ram_we = head_valid && head.store;
      end
      S_IREAD: begin
        ram_re = 1'b1;
      end
      S_IWAIT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_INNER: begin
        if (pend) begin
          ram_we    = swap;
          ram_waddr = jp;
          ram_wdata = {cur_key, cur_tag};
          ram_re    = more_j;
          ram_raddr = jr[AW-1:0];
        end else begin
          // inner pass done: write back a[i], fetch a[i+1]
          ram_we    = 1'b1;
          ram_waddr = idx_i;
          ram_wdata = {cur_key, cur_tag};
          ram_re    = !last_i;
          ram_raddr = idx_i + AW'(1);
        end
      end
      S_EREAD: begin
        ram_re    = 1'b1;
        ram_raddr = eidx;
      end
      S_EWAIT: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Output register: load on emit, clear once taken
      if (state == S_EWAIT && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (head_valid) begin
            if (head.store) begin
              cnt <= cnt + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (head.last) begin
              idx_i <= '0;
              state <= S_IREAD;
            end
          end
        end
        S_IREAD: begin
          state <= S_IWAIT;
        end
        S_IWAIT: begin
          cur_key <= rd_key;
          cur_tag <= rd_tag;
          jp      <= '0;
          jr      <= CW'(1);
          pend    <= 1'b1;
          state   <= S_INNER;
        end
        S_INNER: begin
          if (pend) begin
            if (swap) begin
              cur_key <= rd_key;
              cur_tag <= rd_tag;
            end
            if (more_j) begin
              jp <= jr[AW-1:0];
              jr <= jr + CW'(1);
            end else begin
              pend <= 1'b0;
            end
          end else if (last_i) begin
            eidx  <= '0;
            state <= S_EREAD;
          end else begin
            idx_i <= idx_i + AW'(1);
            state <= S_IWAIT;
          end
        end
        S_EREAD: begin
          state <= S_EWAIT;
        end
        S_EWAIT: begin
          if (out_free) begin
            out_key   <= rd_key;
            out_tag   <= rd_tag;
            out_end   <= last_e;
            out_drop  <= ovf;
            if (last_e) begin
              cnt   <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              eidx  <= eidx + AW'(1);
              state <= S_EREAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/keyed_entry_sorter.sv
// A set of entries is sorted once its closing request leaves the queue; the
// sorted results then leave one at a time, each read back from the store.
// Sorting is bounded by the pairwise compare loop, one pair per cycle on the
// single-read store port.
// Requests queue in a 4-deep buffer while the back end sorts or emits.
// Reset (synchronous, rst high) empties the queue and clears counts and flags.
`default_nettype none

module keyed_entry_sorter #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  kes_entry_if.sink    entries,
  kes_result_if.source results
);
  import kes_pkg::*;

  kes_entry_t head;
  logic       head_valid;
  logic       pop;

  kes_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .entries    (entries),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  kes_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .results    (results)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for keyed_entry_sorter: random and directed entry sets checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import kes_pkg::*;

  localparam int DEPTH       = 64;
  localparam int IDLE_PCT    = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 200;
  localparam int MAX_REPORTS = 10;
  localparam int TOTAL_REQS  = 100;

  // One request to be offered on the entry channel
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } entry_req_t;

  // One sorted result as the block should emit it
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             run_end;
    logic             dropped;
  } sorted_result_t;

  logic clk;
  logic rst;

  kes_entry_if  entries_ch ();
  kes_result_if results_ch ();

  keyed_entry_sorter #(
    .MAX_ENTRIES(DEPTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .entries(entries_ch),
    .results(results_ch)
  );

  entry_req_t     send_q[$];
  sorted_result_t sorted_expect_q[$];

  // Predictor copy of the block's store
  logic [KEY_W-1:0] shadow_keys[DEPTH];
  logic [TAG_W-1:0] shadow_tags[DEPTH];
  int               shadow_count;
  logic             shadow_lost;

  int entries_planned;
  int entries_taken;
  int entries_sent;
  int results_checked;
  int fail_count;
  int hold_left;
  bit hold_used;

  entry_req_t next_req;

  // Clock, reset and known input levels from time zero
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    entries_ch.valid     = 1'b0;
    entries_ch.entry_key = '0;
    entries_ch.entry_tag = '0;
    entries_ch.set_end   = 1'b0;
    results_ch.ready     = 1'b0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (11) @(posedge clk);
        rst <= 1'b0;
      end
    join_none
  end

  task automatic add_req(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                         input logic last);
    entry_req_t r;
    r.key  = key;
    r.tag  = tag;
    r.last = last;
    send_q.push_back(r);
    entries_planned++;
  endtask

  // A set of n entries; half the keys come from a tiny range to force ties
  task automatic add_set(input int n);
    logic [KEY_W-1:0] key;
    for (int k = 0; k < n; k++) begin
      key = $urandom_range(1) ? KEY_W'($urandom) : KEY_W'($urandom_range(7));
      add_req(key, TAG_W'($urandom_range(16'hFFFF)), k == n - 1);
    end
  endtask

  // Store one accepted request; on a closing request sort and queue all results
  task automatic predict_entry(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input logic last);
    logic [KEY_W-1:0] tk;
    logic [TAG_W-1:0] tt;
    sorted_result_t   res;
    if (shadow_count < DEPTH) begin
      shadow_keys[shadow_count] = key;
      shadow_tags[shadow_count] = tag;
      shadow_count++;
    end else begin
      shadow_lost = 1'b1;
    end
    if (last) begin
      // full pairwise exchange: swap whenever key[i] < key[j]
      for (int i = 0; i < shadow_count; i++) begin
        for (int j = 0; j < shadow_count; j++) begin
          if (shadow_keys[i] < shadow_keys[j]) begin
            tk = shadow_keys[j];
            tt = shadow_tags[j];
            shadow_keys[j] = shadow_keys[i];
            shadow_tags[j] = shadow_tags[i];
            shadow_keys[i] = tk;
            shadow_tags[i] = tt;
          end
        end
      end
      for (int k = 0; k < shadow_count; k++) begin
        res.key     = shadow_keys[k];
        res.tag     = shadow_tags[k];
        res.run_end = (k == shadow_count - 1);
        res.dropped = shadow_lost;
        sorted_expect_q.push_back(res);
      end
      shadow_count = 0;
      shadow_lost  = 1'b0;
    end
  endtask

  // Stimulus plan and end of run
  initial begin
    entries_planned = 0;
    shadow_count    = 0;
    shadow_lost     = 1'b0;
    fail_count      = 0;

    // single-entry sets at both key extremes
    add_req(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    add_req(32'h0000_0000, 16'h0000, 1'b1);
    // mixed extremes
    add_req(32'h8000_0000, 16'h0001, 1'b0);
    add_req(32'h7FFF_FFFF, 16'hFFFE, 1'b0);
    add_req(32'hFFFF_FFFF, 16'h8000, 1'b0);
    add_req(32'h0000_0000, 16'h7FFF, 1'b0);
    add_req(32'h0000_0001, 16'hAAAA, 1'b1);
    // ties between keys
    add_req(32'd5, 16'd1, 1'b0);
    add_req(32'd3, 16'd2, 1'b0);
    add_req(32'd5, 16'd3, 1'b0);
    add_req(32'd3, 16'd4, 1'b0);
    add_req(32'd5, 16'd5, 1'b1);
    // all keys equal
    add_req(32'd9, 16'h5555, 1'b0);
    add_req(32'd9, 16'h0010, 1'b0);
    add_req(32'd9, 16'h0011, 1'b1);
    // descending input
    add_req(32'd40, 16'd40, 1'b0);
    add_req(32'd30, 16'd30, 1'b0);
    add_req(32'd20, 16'd20, 1'b0);
    add_req(32'd10, 16'd10, 1'b1);

    // random part: one overflowing set that fills the store, then small sets
    add_set(DEPTH + $urandom_range(1, 4));
    while (entries_planned < TOTAL_REQS)
      add_set($urandom_range(1, 8));

    @(negedge clk);
    while (rst || entries_taken != entries_planned || sorted_expect_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (fail_count == 0 && sorted_expect_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Request driver: random gaps, no gaps across a middle window of requests
  always @(posedge clk) begin
    if (rst) begin
      entries_ch.valid <= 1'b0;
      entries_sent     <= 0;
    end else if (!entries_ch.valid || entries_ch.ready) begin
      if (send_q.size() != 0 &&
          ((entries_sent >= 20 && entries_sent < 90) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        next_req = send_q.pop_front();
        entries_ch.valid     <= 1'b1;
        entries_ch.entry_key <= next_req.key;
        entries_ch.entry_tag <= next_req.tag;
        entries_ch.set_end   <= next_req.last;
        entries_sent         <= entries_sent + 1;
      end else begin
        entries_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, one long hold-off, a stretch with no stalls
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
      hold_left        <= 0;
      hold_used        <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left        <= hold_left - 1;
      results_ch.ready <= 1'b0;
    end else if (!hold_used && results_ch.valid && results_checked >= 40) begin
      hold_left        <= HOLD_CYCLES;
      hold_used        <= 1'b1;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= (results_checked >= 70 && results_checked < 150) ||
                          ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Predict on accepted requests, then check accepted results in order
  always @(posedge clk) begin
    sorted_result_t exp_res;
    if (rst) begin
      entries_taken   <= 0;
      results_checked <= 0;
    end else begin
      if (entries_ch.valid && entries_ch.ready) begin
        predict_entry(entries_ch.entry_key, entries_ch.entry_tag, entries_ch.set_end);
        entries_taken <= entries_taken + 1;
      end
      if (results_ch.valid && results_ch.ready) begin
        results_checked <= results_checked + 1;
        if (sorted_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: key %h tag %h end %b dropped %b",
                     results_ch.sorted_key, results_ch.sorted_tag,
                     results_ch.run_end, results_ch.entries_dropped);
        end else begin
          exp_res = sorted_expect_q.pop_front();
          if (results_ch.sorted_key !== exp_res.key ||
              results_ch.sorted_tag !== exp_res.tag ||
              results_ch.run_end !== exp_res.run_end ||
              results_ch.entries_dropped !== exp_res.dropped) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"result %0d mismatch: exp key %h tag %h end %b dropped %b,",
                        " got key %h tag %h end %b dropped %b"},
                       results_checked, exp_res.key, exp_res.tag, exp_res.run_end,
                       exp_res.dropped, results_ch.sorted_key, results_ch.sorted_tag,
                       results_ch.run_end, results_ch.entries_dropped);
          end
        end
      end
    end
  end

endmodule
